[rtl/core/pixel_row_downscale_convert_core_defines.svh]
// ----------------------------------------------------------------------------
// Pixel row downscale convert core: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PIXEL_ROW_DOWNSCALE_CONVERT_CORE_DEFINES_SVH
`define PIXEL_ROW_DOWNSCALE_CONVERT_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PRDC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PRDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/prdc_pkg.sv]
// ----------------------------------------------------------------------------
// Pixel row downscale convert package
// Mode and register codes, lane control type and channel extraction.
// ----------------------------------------------------------------------------
package prdc_pkg;

  // Conversion modes.
  localparam logic [1:0] MODE_RGBA      = 2'd0;
  localparam logic [1:0] MODE_RGBA_565  = 2'd1;
  localparam logic [1:0] MODE_565       = 2'd2;
  localparam logic [1:0] MODE_RESERVED  = 2'd3;

  // Register indexes (byte address 4 * index).
  localparam logic REG_CONV_MODE = 1'b0;
  localparam logic REG_RATIO     = 1'b1;

  localparam int NUM_LANES = 4;
  localparam int CH_W      = 8;
  localparam int SUM_W     = 10;
  localparam int RATIO_W   = 7;
  localparam int MODE_W    = 2;

  // Masks of the RGB565 fields.
  localparam logic [7:0] MASK5 = 8'h1f;
  localparam logic [7:0] MASK6 = 8'h3f;

  // Channel lane indexes.
  localparam logic [1:0] LANE_R = 2'd0;
  localparam logic [1:0] LANE_G = 2'd1;
  localparam logic [1:0] LANE_B = 2'd2;
  localparam logic [1:0] LANE_A = 2'd3;

  // Per-item control of one channel lane.
  typedef struct packed {
    logic load;   // item accepted in group mode: sum register updates
    logic clear;  // first column of a group: start from zero
    logic accum;  // column lies in the sampled pair of the group
  } lane_ctl_t;

  // Pull one channel out of a pixel for the source format of the mode.
  function automatic logic [CH_W-1:0] split_channel(input logic [MODE_W-1:0] mode,
                                                    input logic [31:0] px,
                                                    input logic [1:0] lane);
    logic [CH_W-1:0] ch;
    ch = '0;
    if (mode == MODE_565) begin
      case (lane)
        LANE_R:  ch = px[18:11] & MASK5;
        LANE_G:  ch = px[12:5] & MASK6;
        LANE_B:  ch = px[7:0] & MASK5;
        default: ch = '0;
      endcase
    end else begin
      case (lane)
        LANE_R:  ch = px[7:0];
        LANE_G:  ch = px[15:8];
        LANE_B:  ch = px[23:16];
        default: ch = px[31:24];
      endcase
    end
    return ch;
  endfunction

endpackage

[rtl/core/prdc_lane.sv]
// ----------------------------------------------------------------------------
// Pixel row downscale convert: channel lane
// Accumulates one channel over the sampled 2x2 block and gives its average.
// ----------------------------------------------------------------------------
module prdc_lane (
  input  logic                      clk,
  input  logic                      rst,
  input  prdc_pkg::lane_ctl_t       ctl,
  input  logic [prdc_pkg::CH_W-1:0] top_ch,
  input  logic [prdc_pkg::CH_W-1:0] bot_ch,
  output logic [prdc_pkg::CH_W-1:0] avg
);

  logic [prdc_pkg::SUM_W-1:0] sum;
  logic [prdc_pkg::SUM_W-1:0] sum_base;
  logic [prdc_pkg::SUM_W-1:0] sum_add;
  logic [prdc_pkg::SUM_W-1:0] sum_next;

  // Column pair contribution, wrapped to the sum width.
  always_comb begin
    sum_base = ctl.clear ? '0 : sum;
    sum_add  = ctl.accum ? (prdc_pkg::SUM_W'(top_ch) + prdc_pkg::SUM_W'(bot_ch)) : '0;
    sum_next = sum_base + sum_add;
  end

  // Average of four pixels is the updated sum divided by four.
  assign avg = sum_next[prdc_pkg::SUM_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctl.load) begin
      sum <= sum_next;
    end
  end

endmodule

[rtl/core/prdc_pack.sv]
// ----------------------------------------------------------------------------
// Pixel row downscale convert: output packer
// Merges the lane averages, or the pass-through pixel, into the output format.
// ----------------------------------------------------------------------------
module prdc_pack (
  input  logic [prdc_pkg::MODE_W-1:0]                        mode,
  input  logic                                               ratio_one,
  input  logic [31:0]                                        top_pixel,
  input  logic [prdc_pkg::NUM_LANES-1:0][prdc_pkg::CH_W-1:0] avg,
  output logic [31:0]                                        out_pixel
);

  function automatic logic [31:0] pack565(input logic [7:0] r5,
                                          input logic [7:0] g6,
                                          input logic [7:0] b5);
    return {16'd0, r5[4:0], g6[5:0], b5[4:0]};
  endfunction

  always_comb begin
    if (ratio_one) begin
      // Direct copy or conversion of the upper pixel.
      unique case (mode)
        prdc_pkg::MODE_RGBA_565:
          out_pixel = pack565(top_pixel[7:0] >> 3, top_pixel[15:8] >> 2,
                              top_pixel[23:16] >> 3);
        prdc_pkg::MODE_565:
          out_pixel = {16'd0, top_pixel[15:0]};
        default:
          out_pixel = top_pixel;
      endcase
    end else begin
      // Box average of the group.
      unique case (mode)
        prdc_pkg::MODE_RGBA_565:
          out_pixel = pack565(avg[prdc_pkg::LANE_R] >> 3, avg[prdc_pkg::LANE_G] >> 2,
                              avg[prdc_pkg::LANE_B] >> 3);
        prdc_pkg::MODE_565:
          out_pixel = pack565(avg[prdc_pkg::LANE_R], avg[prdc_pkg::LANE_G],
                              avg[prdc_pkg::LANE_B]);
        default:
          out_pixel = {avg[prdc_pkg::LANE_A], avg[prdc_pkg::LANE_B],
                       avg[prdc_pkg::LANE_G], avg[prdc_pkg::LANE_R]};
      endcase
    end
  end

endmodule

[rtl/core/pixel_row_downscale_convert_core.sv]
// A result item is registered on accept, in the skid register behind a stalled output.
// Throughput: one column pair per cycle; four lanes update on accept, in group mode only.
// s_tready drops only while a result waits in the skid register behind a stalled output.
// Reset (rst, synchronous, active high): conv_mode 0, ratio 1, group position and sums 0,
// output and skid registers empty.
// ----------------------------------------------------------------------------
// Pixel row downscale convert core
// Box downscale of two source rows with RGBA8888 / RGB565 conversion.
// ----------------------------------------------------------------------------
`include "pixel_row_downscale_convert_core_defines.svh"

module pixel_row_downscale_convert_core #(
  parameter int MAX_RATIO = 64
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // top_pixel [31:0], bottom_pixel [63:32]
  input  logic        s_tuser,   // row_start [0]
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // out_pixel [31:0]
);

  localparam int PW = (MAX_RATIO > 2) ? $clog2(MAX_RATIO) : 1;
  localparam int CW = $clog2(MAX_RATIO + 1);
  localparam int EW = (CW > prdc_pkg::RATIO_W) ? CW : prdc_pkg::RATIO_W;
  localparam logic [EW-1:0] MAX_RATIO_E = EW'(MAX_RATIO);

  // Configuration registers.
  logic [prdc_pkg::MODE_W-1:0]  conv_mode;
  logic [prdc_pkg::RATIO_W-1:0] ratio;
  logic                         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      conv_mode <= prdc_pkg::MODE_RGBA;
      ratio     <= prdc_pkg::RATIO_W'(1);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        prdc_pkg::REG_CONV_MODE: conv_mode <= pwdata[prdc_pkg::MODE_W-1:0];
        default:                 ratio     <= pwdata[prdc_pkg::RATIO_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      prdc_pkg::REG_CONV_MODE: prdata = {30'd0, conv_mode};
      default:                 prdata = {25'd0, ratio};
    endcase
  end

  // Effective mode and ratio.
  logic [prdc_pkg::MODE_W-1:0] mode_eff;
  logic [EW-1:0]               ratio_ext;
  logic [EW-1:0]               ratio_eff;
  logic                        ratio_one;

  always_comb begin
    mode_eff  = (conv_mode == prdc_pkg::MODE_RESERVED) ? prdc_pkg::MODE_RGBA : conv_mode;
    ratio_ext = EW'(ratio);
    if (ratio_ext == '0) begin
      ratio_eff = EW'(1);
    end else if (ratio_ext > MAX_RATIO_E) begin
      ratio_eff = MAX_RATIO_E;
    end else begin
      ratio_eff = ratio_ext;
    end
    ratio_one = (ratio_eff == EW'(1));
  end

  // Input unpacking and handshake.
  logic [31:0] top_pixel;
  logic [31:0] bottom_pixel;
  logic        row_start;
  logic        in_fire;

  assign top_pixel    = s_tdata[31:0];
  assign bottom_pixel = s_tdata[63:32];
  assign row_start    = s_tuser;
  assign in_fire      = s_tvalid && s_tready;

  // Group position tracking.
  logic [PW-1:0] group_pos;
  logic [PW-1:0] group_pos_next;
  logic [EW-1:0] pos_ext;
  logic [EW-1:0] last_col;
  logic [EW-1:0] start_col;
  logic          sample_hit;
  logic          group_done;
  logic          has_result;

  always_comb begin
    pos_ext        = row_start ? '0 : EW'(group_pos);
    last_col       = ratio_eff - EW'(1);
    start_col      = (ratio_eff - EW'(2)) >> 1;
    sample_hit     = (pos_ext == start_col) || (pos_ext == start_col + EW'(1));
    group_done     = (pos_ext >= last_col);
    has_result     = ratio_one || group_done;
    group_pos_next = group_done ? '0 : PW'(pos_ext + EW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_pos <= '0;
    end else if (in_fire && !ratio_one) begin
      group_pos <= group_pos_next;
    end
  end

  // Channel lanes.
  prdc_pkg::lane_ctl_t                                ctl;
  logic [prdc_pkg::NUM_LANES-1:0][prdc_pkg::CH_W-1:0] avg;

  assign ctl.load  = in_fire && !ratio_one;
  assign ctl.clear = (pos_ext == '0);
  assign ctl.accum = sample_hit;

  for (genvar ln = 0; ln < prdc_pkg::NUM_LANES; ln++) begin : g_lane
    prdc_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .top_ch (prdc_pkg::split_channel(mode_eff, top_pixel, 2'(ln))),
      .bot_ch (prdc_pkg::split_channel(mode_eff, bottom_pixel, 2'(ln))),
      .avg    (avg[ln])
    );
  end

  // Merge lanes into the output pixel.
  logic [31:0] out_pixel;

  prdc_pack u_pack (
    .mode      (mode_eff),
    .ratio_one (ratio_one),
    .top_pixel (top_pixel),
    .avg       (avg),
    .out_pixel (out_pixel)
  );

  // Output register with a skid stage.
  logic        out_valid;
  logic [31:0] out_data;
  logic        skid_valid;
  logic [31:0] skid_data;
  logic        out_fire;
  logic        push;

  assign out_fire = out_valid && m_tready;
  assign push     = in_fire && has_result;
  assign s_tready = !skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_fire || !out_valid) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_fire || !out_valid) begin
        out_data <= out_pixel;
      end else begin
        skid_data <= out_pixel;
      end
    end
  end

  // Checks.
  `PRDC_ASSERT_SAME(a_skid_behind_out, skid_valid, out_valid, "skid full while output empty")
  `PRDC_ASSERT_NEXT(a_pass_gives_item, in_fire && ratio_one, m_tvalid,
                    "pass-through item produced no result")
  `PRDC_ASSERT_NEXT(a_skid_holds, skid_valid && !m_tready, skid_valid && $stable(skid_data),
                    "skid item lost while output stalled")
  `PRDC_ASSERT_SAME(a_pos_in_range, 1'b1, EW'(group_pos) < MAX_RATIO_E,
                    "group position beyond maximum ratio")

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// Pixel row downscale convert core testbench
// Drives column pairs through the stream input under several register
// settings and idle patterns. A built-in predictor keeps its own copy of the
// group position and channel sums, and each output item is compared in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int MAX_RATIO     = 64;
  localparam int SETTLE_CYCLES = 4;
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 200;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_kind_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata  = '0;   // top_pixel [31:0], bottom_pixel [63:32]
  logic        s_tuser  = 1'b0; // row_start [0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // out_pixel [31:0]

  // Predictor state: register copies, group position and per-channel sums.
  logic [1:0]       cfg_mode  = prdc_pkg::MODE_RGBA;
  logic [6:0]       cfg_ratio = 7'd1;
  logic [5:0]       grp_pos   = '0;
  logic [3:0][9:0]  lane_sum  = '0;

  logic [31:0] pending_pixels [$];
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int columns_sent   = 0;
  int pixels_checked = 0;
  int settings_count = 0;
  int mismatch_count = 0;
  int quiet_cycles   = 0;

  // Random phase settings; the ratio list includes zero and a saturating value.
  int unsigned phase_ratio [12] = '{2, 1, 3, 4, 64, 5, 0, 8, 127, 6, 2, 16};
  logic [1:0]  phase_mode  [4]  = '{prdc_pkg::MODE_RGBA, prdc_pkg::MODE_RGBA_565,
                                    prdc_pkg::MODE_565, prdc_pkg::MODE_RESERVED};

  pixel_row_downscale_convert_core #(
    .MAX_RATIO(MAX_RATIO)
  ) dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("ERROR: %s", what);
  endtask

  // Effective ratio: zero acts as one, large values saturate.
  function automatic logic [6:0] eff_ratio();
    if (cfg_ratio == 7'd0) return 7'd1;
    if (cfg_ratio > MAX_RATIO) return 7'(MAX_RATIO);
    return cfg_ratio;
  endfunction

  // Channels of a pixel as four bytes, r in the lowest, for the source format.
  function automatic logic [31:0] lanes_of(input logic [1:0] mode, input logic [31:0] px);
    if (mode == prdc_pkg::MODE_565)
      return {8'd0, 3'd0, px[4:0], 2'd0, px[10:5], 3'd0, px[15:11]};
    return px;
  endfunction

  function automatic logic [31:0] pack_565(input logic [7:0] r5, input logic [7:0] g6,
                                           input logic [7:0] b5);
    return {16'd0, r5[4:0], g6[5:0], b5[4:0]};
  endfunction

  // Advances the predictor by one column pair; returns 1 when a pixel is due.
  function automatic bit downscale_column(input logic [31:0] top, input logic [31:0] bot,
                                          input logic rs, output logic [31:0] px);
    logic [1:0]      mode;
    logic [6:0]      r;
    logic [6:0]      first_col;
    logic [31:0]     ta;
    logic [31:0]     ba;
    logic [3:0][7:0] avg;
    mode = (cfg_mode == prdc_pkg::MODE_RESERVED) ? prdc_pkg::MODE_RGBA : cfg_mode;
    r    = eff_ratio();
    px   = '0;
    // Ratio one passes the upper pixel and leaves group state untouched.
    if (r == 7'd1) begin
      case (mode)
        prdc_pkg::MODE_RGBA:     px = top;
        prdc_pkg::MODE_RGBA_565: px = pack_565(top[7:0] >> 3, top[15:8] >> 2,
                                               top[23:16] >> 3);
        default:                 px = {16'd0, top[15:0]};
      endcase
      return 1'b1;
    end
    if (rs) grp_pos = '0;
    if (grp_pos == 6'd0) lane_sum = '0;
    // Only the two middle columns of the group are summed.
    first_col = (r - 7'd2) / 7'd2;
    if (grp_pos == first_col || grp_pos == first_col + 7'd1) begin
      ta = lanes_of(mode, top);
      ba = lanes_of(mode, bot);
      for (int i = 0; i < 4; i++) lane_sum[i] = lane_sum[i] + ta[8*i +: 8] + ba[8*i +: 8];
    end
    if (grp_pos >= r - 7'd1) begin
      grp_pos = '0;
      for (int i = 0; i < 4; i++) avg[i] = lane_sum[i][9:2];
      case (mode)
        prdc_pkg::MODE_RGBA:     px = avg;
        prdc_pkg::MODE_RGBA_565: px = pack_565(avg[0] >> 3, avg[1] >> 2, avg[2] >> 3);
        default:                 px = pack_565(avg[0], avg[1], avg[2]);
      endcase
      return 1'b1;
    end
    grp_pos = grp_pos + 6'd1;
    return 1'b0;
  endfunction

  // Receiver: long hold-off when requested, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready = 1'b0;
      hold_left--;
    end else begin
      m_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Output checker: each item is compared with the oldest predicted pixel.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected output item %08h", m_tdata));
      end else if (m_tdata !== pending_pixels[0]) begin
        report_mismatch($sformatf("out_pixel expected %08h actual %08h",
                                  pending_pixels[0], m_tdata));
        void'(pending_pixels.pop_front());
      end else begin
        void'(pending_pixels.pop_front());
      end
      pixels_checked++;
    end
  end

  // Watchdog: ends the run when nothing moves on either stream for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout after %0d quiet cycles", quiet_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic set_idling(input idle_kind_t kind);
    case (kind)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 82; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 82; end
      default:   begin send_idle_pct = 24; recv_stall_pct = 24; end
    endcase
  endtask

  // Offers one column pair and waits until it is accepted.
  task automatic send_column(input logic [31:0] top, input logic [31:0] bot, input logic rs);
    logic [31:0] px;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {bot, top};
    s_tuser  = rs;
    do @(posedge clk); while (!s_tready);
    if (downscale_column(top, bot, rs, px)) pending_pixels.push_back(px);
    columns_sent++;
  endtask

  // Stops offering items and waits for every predicted pixel to come out.
  task automatic drain_results();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write followed by a read back of the same register.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    logic [31:0] readback;
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (idx == prdc_pkg::REG_CONV_MODE) cfg_mode = value[1:0];
    else cfg_ratio = value[6:0];
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    readback = (idx == prdc_pkg::REG_CONV_MODE) ? {30'd0, cfg_mode} : {25'd0, cfg_ratio};
    if (prdata !== readback)
      report_mismatch($sformatf("register %0d read expected %08h actual %08h",
                                idx, readback, prdata));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic apply_settings(input logic [1:0] mode, input logic [6:0] ratio);
    drain_results();
    write_reg(prdc_pkg::REG_CONV_MODE, {30'd0, mode});
    write_reg(prdc_pkg::REG_RATIO, {25'd0, ratio});
    settings_count++;
  endtask

  // Mostly random pixels, with a share of all-zero and all-one halves.
  function automatic logic [31:0] random_pixel();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h0000_ffff;
      default: return $urandom();
    endcase
  endfunction

  // Pass-through at ratio one (and ratio zero) in every mode code.
  task automatic test_ratio_one();
    set_idling(IDLE_NONE);
    apply_settings(prdc_pkg::MODE_RGBA, 7'd1);
    send_column(32'h0000_0000, 32'hffff_ffff, 1'b1);
    send_column(32'hffff_ffff, 32'h0000_0000, 1'b0);
    send_column(32'ha5a5_5a5a, 32'h5a5a_a5a5, 1'b0);
    apply_settings(prdc_pkg::MODE_RGBA_565, 7'd1);
    send_column(32'hffff_ffff, 32'h0000_0000, 1'b0);
    send_column(32'h1234_5678, 32'hffff_ffff, 1'b1);
    apply_settings(prdc_pkg::MODE_565, 7'd1);
    send_column(32'hdead_beef, 32'h0000_0000, 1'b0);
    apply_settings(prdc_pkg::MODE_RESERVED, 7'd1);
    send_column(32'h89ab_cdef, 32'h0123_4567, 1'b0);
    apply_settings(prdc_pkg::MODE_RGBA_565, 7'd0);
    send_column(32'hfedc_ba98, 32'h7654_3210, 1'b1);
  endtask

  // Full-scale sums and the smallest groups in each source format.
  task automatic test_group_extremes();
    apply_settings(prdc_pkg::MODE_RGBA, 7'd2);
    send_column(32'hffff_ffff, 32'hffff_ffff, 1'b1);
    send_column(32'hffff_ffff, 32'hffff_ffff, 1'b0);
    apply_settings(prdc_pkg::MODE_565, 7'd2);
    send_column(32'hffff_ffff, 32'hffff_ffff, 1'b1);
    send_column(32'h0000_ffff, 32'h0000_0000, 1'b0);
    apply_settings(prdc_pkg::MODE_RGBA_565, 7'd3);
    send_column(32'h00ff_00ff, 32'hff00_ff00, 1'b1);
    send_column(32'hffff_ffff, 32'h8080_8080, 1'b0);
    send_column(32'h0000_0000, 32'hffff_ffff, 1'b0);
  endtask

  // A row start in the middle of a group drops the partial group.
  task automatic test_row_restart();
    apply_settings(prdc_pkg::MODE_RGBA, 7'd4);
    send_column(32'h1111_1111, 32'h2222_2222, 1'b1);
    send_column(32'hffff_ffff, 32'hffff_ffff, 1'b0);
    send_column(32'h3333_3333, 32'h4444_4444, 1'b0);
    send_column(32'h0102_0304, 32'h0506_0708, 1'b1);
    send_column(32'h10f0_8040, 32'hf010_4080, 1'b0);
    send_column(32'h7f7f_7f7f, 32'h8181_8181, 1'b0);
    send_column(32'h0000_0000, 32'h0000_0000, 1'b0);
  endtask

  // New settings inside a group: a position past the new last column emits at once.
  task automatic test_midgroup_change();
    apply_settings(prdc_pkg::MODE_RGBA, 7'd8);
    send_column(32'h0000_0000, 32'h0000_0000, 1'b1);
    send_column(32'hffff_ffff, 32'hffff_ffff, 1'b0);
    send_column(32'h1234_5678, 32'h9abc_def0, 1'b0);
    send_column(32'hfedc_ba98, 32'h7654_3210, 1'b0);
    apply_settings(prdc_pkg::MODE_565, 7'd4);
    send_column(32'h5555_aaaa, 32'haaaa_5555, 1'b0);
    send_column(32'h0000_f81f, 32'h0000_07e0, 1'b0);
  endtask

  // Receiver holds off while the sender keeps offering, then the sender pauses.
  task automatic test_backpressure();
    set_idling(IDLE_NONE);
    apply_settings(prdc_pkg::MODE_RGBA, 7'd1);
    @(negedge clk);
    hold_left = HOLD_CYCLES;
    repeat (40) send_column(random_pixel(), random_pixel(), 1'($urandom_range(1)));
    drain_results();
  endtask

  // Rows of random content, mostly whole groups, some partial rows and stray flags.
  task automatic send_rows(input int n_items);
    int          left;
    int          row_len;
    int          r;
    int          roll;
    logic        rs;
    left = n_items;
    while (left > 0) begin
      r    = int'(eff_ratio());
      roll = $urandom_range(99);
      if (roll < 80) row_len = r * $urandom_range(1, 4);
      else if (roll < 95) row_len = $urandom_range(1, 2 * r);
      else row_len = 1;
      if (row_len > left) row_len = left;
      for (int col = 0; col < row_len; col++) begin
        rs = (col == 0);
        if ($urandom_range(99) < 3) rs = ~rs;
        send_column(random_pixel(), random_pixel(), rs);
      end
      left -= row_len;
    end
  endtask

  // Random phases; a partial group may carry over into the next setting.
  task automatic test_random_phases();
    for (int p = 0; p < 12; p++) begin
      apply_settings(phase_mode[p % 4], 7'(phase_ratio[p]));
      set_idling(idle_kind_t'(p / 3));
      send_rows(85);
    end
    set_idling(IDLE_NONE);
    drain_results();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_ratio_one();
    test_group_extremes();
    test_row_restart();
    test_midgroup_change();
    test_backpressure();
    test_random_phases();

    drain_results();
    repeat (8) @(posedge clk);
    if (pending_pixels.size() != 0)
      report_mismatch($sformatf("%0d predicted pixels never arrived", pending_pixels.size()));

    $display("Summary: %0d column items, %0d output pixels, %0d register settings.",
             columns_sent, pixels_checked, settings_count);
    $display("Covered all mode codes, ratios one to saturation, row restarts and stalls.");
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Mismatches: %0d", mismatch_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
